@@ rtl/core/shd_pkg.sv @@
// Package for the shift-history button debouncer.
// Holds sizes, register indexes and shared types; no dependencies.
`timescale 1ns / 1ps

package shd_pkg;

    // Buttons kept in state, and the width of every per-button field.
    localparam int BUTTON_COUNT = 8;
    localparam int FIELD_WIDTH  = 8;
    // Lanes actually built: a button beyond the field width is never scanned.
    localparam int LANE_COUNT   = (BUTTON_COUNT < FIELD_WIDTH) ? BUTTON_COUNT : FIELD_WIDTH;

    localparam int HIST_WIDTH   = 8;
    localparam int COUNT_WIDTH  = 4;
    localparam int CFG_WIDTH    = 8;
    localparam int INDEX_WIDTH  = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_BITS      = FIELD_WIDTH;
    localparam int IN_WIDTH     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 4 * FIELD_WIDTH + 1;
    localparam int OUT_WIDTH    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_BOUNCE_MASK     = 3'd0,
        REG_UP_PATTERN      = 3'd1,
        REG_DOWN_PATTERN    = 3'd2,
        REG_PRESS_PATTERN   = 3'd3,
        REG_RELEASE_PATTERN = 3'd4,
        REG_ACTIVE_COUNT    = 3'd5
    } reg_index_t;

    // Reset values of the configuration registers.
    localparam logic [HIST_WIDTH-1:0]  BOUNCE_MASK_RST     = 8'd199;
    localparam logic [HIST_WIDTH-1:0]  UP_PATTERN_RST      = 8'd0;
    localparam logic [HIST_WIDTH-1:0]  DOWN_PATTERN_RST    = 8'd255;
    localparam logic [HIST_WIDTH-1:0]  PRESS_PATTERN_RST   = 8'd7;
    localparam logic [HIST_WIDTH-1:0]  RELEASE_PATTERN_RST = 8'd192;
    localparam logic [COUNT_WIDTH-1:0] ACTIVE_COUNT_RST    = 4'd8;

    // Pattern settings shared by every lane.
    typedef struct packed {
        logic [HIST_WIDTH-1:0] bounce_mask;
        logic [HIST_WIDTH-1:0] up_pattern;
        logic [HIST_WIDTH-1:0] down_pattern;
        logic [HIST_WIDTH-1:0] press_pattern;
        logic [HIST_WIDTH-1:0] release_pattern;
    } pattern_cfg_t;

    // Flags one lane reports for one poll tick.
    typedef struct packed {
        logic down;
        logic up;
        logic press;
        logic release_edge;
    } lane_flags_t;

    // One result item.
    typedef struct packed {
        logic                   any_down;
        logic [FIELD_WIDTH-1:0] release_flags;
        logic [FIELD_WIDTH-1:0] press_flags;
        logic [FIELD_WIDTH-1:0] up_flags;
        logic [FIELD_WIDTH-1:0] down_flags;
    } result_t;

endpackage

@@ rtl/core/shd_lane.sv @@
// One debouncer lane: the shift history of a single button and its edge tests.
// Depends on shd_pkg for the pattern and flag types.
`timescale 1ns / 1ps

module shd_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,    // a poll request is accepted this cycle
    input  logic                 active,     // this button is scanned
    input  logic                 raw_sample,
    input  shd_pkg::pattern_cfg_t cfg,
    output shd_pkg::lane_flags_t flags
);

    logic [shd_pkg::HIST_WIDTH-1:0] history_reg;
    logic [shd_pkg::HIST_WIDTH-1:0] history_next;
    logic [shd_pkg::HIST_WIDTH-1:0] shifted;
    logic [shd_pkg::HIST_WIDTH-1:0] after_press;
    logic                           press_hit;
    logic                           release_hit;

    // Shift in the sample, then the press test, then the release test on the
    // possibly rewritten history.
    always_comb
    begin
        shifted      = {history_reg[shd_pkg::HIST_WIDTH-2:0], raw_sample};
        press_hit    = ((shifted & cfg.bounce_mask) == cfg.press_pattern);
        after_press  = press_hit ? cfg.down_pattern : shifted;
        release_hit  = ((after_press & cfg.bounce_mask) == cfg.release_pattern);
        history_next = release_hit ? cfg.up_pattern : after_press;
    end

    // Flags are zero for a button outside the scanned range.
    always_comb
    begin
        flags.down         = active && (history_next == cfg.down_pattern);
        flags.up           = active && (history_next == cfg.up_pattern);
        flags.press        = active && press_hit;
        flags.release_edge = active && release_hit;
    end

    // The history moves only for a scanned button on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
        end
        else if (advance && active)
        begin
            history_reg <= history_next;
        end
    end

endmodule

@@ rtl/core/shd_merge.sv @@
// Merging stage: gathers the lane flags into one result and buffers it.
// Depends on shd_pkg; an output register plus a skid register decouple the sides.
`timescale 1ns / 1ps

module shd_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,       // a poll request is accepted this cycle
    input  shd_pkg::lane_flags_t lane_flags [shd_pkg::LANE_COUNT],
    output logic                 space,      // the buffer can take one more result
    output logic                 out_valid,
    input  logic                 out_ready,
    output shd_pkg::result_t     out_result
);

    shd_pkg::result_t merged;
    shd_pkg::result_t out_data_reg;
    shd_pkg::result_t skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             pop;

    // Combine the lanes; fields above the lane count stay zero.
    always_comb
    begin
        merged = '0;
        for (int i = 0; i < shd_pkg::LANE_COUNT; i++)
        begin
            merged.down_flags[i]    = lane_flags[i].down;
            merged.up_flags[i]      = lane_flags[i].up;
            merged.press_flags[i]   = lane_flags[i].press;
            merged.release_flags[i] = lane_flags[i].release_edge;
        end
        merged.any_down = |merged.down_flags;
    end

    assign pop        = out_valid_reg && out_ready;
    assign space      = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    // Valid bits of the output and skid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop && skid_valid_reg)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (pop || !out_valid_reg)
        begin
            if (push)
            begin
                out_data_reg <= merged;
            end
        end
        else if (push)
        begin
            skid_data_reg <= merged;
        end
    end

endmodule

@@ rtl/core/shift_history_button_debouncer_top.sv @@
// Top level of the shift-history button debouncer.
// Depends on shd_pkg, shd_lane and shd_merge.
//
//  Channel   Signals                    Direction  Payload
//  poll in   s_tvalid/s_tready/s_tdata  slave      raw_samples
//  result    m_tvalid/m_tready/m_tdata  master     down, up, press, release, any_down
//  config    cfg_we/cfg_index/cfg_data  write      six pattern and count registers
//
// One poll request is taken every cycle while the buffer has space; all button lanes update
// in parallel and the result is registered in the output register, or in the skid register.
// The output register and a skid register hold up to two results, so a stalled
// master blocks the slave side only once both are full.
// Reset clears every button history and loads the default patterns; no clearing pass.
`timescale 1ns / 1ps

module shift_history_button_debouncer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Poll tick: [7:0] raw_samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [shd_pkg::IN_WIDTH-1:0]        s_tdata,
    // Result: [7:0] down_flags, [15:8] up_flags, [23:16] press_flags,
    // [31:24] release_flags, [32] any_down, [39:33] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [shd_pkg::OUT_WIDTH-1:0]       m_tdata,
    // Register writes
    input  logic                                cfg_we,
    input  logic [shd_pkg::INDEX_WIDTH-1:0]     cfg_index,
    input  logic [shd_pkg::CFG_WIDTH-1:0]       cfg_data
);

    shd_pkg::pattern_cfg_t              cfg_reg;
    logic [shd_pkg::COUNT_WIDTH-1:0]    active_count_reg;
    shd_pkg::lane_flags_t               lane_flags [shd_pkg::LANE_COUNT];
    shd_pkg::result_t                   result;
    logic [shd_pkg::FIELD_WIDTH-1:0]    raw_samples;
    logic                               accept;
    logic                               space;

    assign raw_samples = s_tdata[shd_pkg::FIELD_WIDTH-1:0];
    assign s_tready    = space;
    assign accept      = s_tvalid && space;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bounce_mask     <= shd_pkg::BOUNCE_MASK_RST;
            cfg_reg.up_pattern      <= shd_pkg::UP_PATTERN_RST;
            cfg_reg.down_pattern    <= shd_pkg::DOWN_PATTERN_RST;
            cfg_reg.press_pattern   <= shd_pkg::PRESS_PATTERN_RST;
            cfg_reg.release_pattern <= shd_pkg::RELEASE_PATTERN_RST;
            active_count_reg        <= shd_pkg::ACTIVE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                shd_pkg::REG_BOUNCE_MASK:     cfg_reg.bounce_mask     <= cfg_data;
                shd_pkg::REG_UP_PATTERN:      cfg_reg.up_pattern      <= cfg_data;
                shd_pkg::REG_DOWN_PATTERN:    cfg_reg.down_pattern    <= cfg_data;
                shd_pkg::REG_PRESS_PATTERN:   cfg_reg.press_pattern   <= cfg_data;
                shd_pkg::REG_RELEASE_PATTERN: cfg_reg.release_pattern <= cfg_data;
                shd_pkg::REG_ACTIVE_COUNT:
                begin
                    active_count_reg <= cfg_data[shd_pkg::COUNT_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // One lane per button; a lane is scanned when its index is below the count,
    // which also saturates the count at the number of lanes.
    for (genvar g = 0; g < shd_pkg::LANE_COUNT; g++)
    begin : g_lane
        shd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (accept),
            .active     (shd_pkg::COUNT_WIDTH'(g) < active_count_reg),
            .raw_sample (raw_samples[g]),
            .cfg        (cfg_reg),
            .flags      (lane_flags[g])
        );
    end

    // Merge lane flags and buffer the result.
    shd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .lane_flags (lane_flags),
        .space      (space),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result, first field in the lowest bits.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[shd_pkg::OUT_BITS-1:0] = {result.any_down, result.release_flags,
                                          result.press_flags, result.up_flags,
                                          result.down_flags};
    end

endmodule

@@ bench/tb_shift_history_button_debouncer_top.sv @@
// Self-checking testbench for the shift-history button debouncer top level.
// Drives poll requests and register writes, predicts each scan result and compares it.
// Depends on shd_pkg and shift_history_button_debouncer_top.
`timescale 1ns / 1ps

module tb_shift_history_button_debouncer_top;

    import shd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_PAD   = 4;

    // Indexes beyond the register list; writes to them must be ignored.
    localparam logic [INDEX_WIDTH-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [INDEX_WIDTH-1:0] SPARE_INDEX_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_WIDTH-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_WIDTH-1:0]   m_tdata;
    logic                   cfg_we;
    logic [INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;

    shift_history_button_debouncer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the registers and the per-button histories.
    logic [HIST_WIDTH-1:0]  cur_mask;
    logic [HIST_WIDTH-1:0]  cur_up;
    logic [HIST_WIDTH-1:0]  cur_down;
    logic [HIST_WIDTH-1:0]  cur_press;
    logic [HIST_WIDTH-1:0]  cur_release;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [HIST_WIDTH-1:0]  btn_hist [BUTTON_COUNT];

    result_t pending_scans [$];

    int fail_count;
    int polls_accepted;
    int results_checked;
    int press_seen;
    int release_seen;
    int settings_applied;
    int cycle_count;

    // Sender pacing and receiver hold-off control.
    int burst_left;
    bit gaps_allowed;
    bit hold_request;

    // Per-button level and bounce state for realistic raw samples.
    bit btn_level  [FIELD_WIDTH];
    int bounce_left[FIELD_WIDTH];

    // One poll tick through the shadow histories; returns the expected result.
    function automatic result_t predict_scan(input logic [FIELD_WIDTH-1:0] raw);
        result_t               r;
        int                    n;
        logic [HIST_WIDTH-1:0] h;
        r = '0;
        n = int'(cur_count);
        if (n > LANE_COUNT)
            n = LANE_COUNT;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            if (i < n)
            begin
                h = {btn_hist[i][HIST_WIDTH-2:0], raw[i]};
                // The press test rewrites first; the release test sees the new value.
                if ((h & cur_mask) == cur_press)
                begin
                    h = cur_down;
                    r.press_flags[i] = 1'b1;
                end
                if ((h & cur_mask) == cur_release)
                begin
                    h = cur_up;
                    r.release_flags[i] = 1'b1;
                end
                btn_hist[i] = h;
                r.down_flags[i] = (h == cur_down);
                r.up_flags[i]   = (h == cur_up);
            end
        end
        r.any_down = |r.down_flags;
        return r;
    endfunction

    // Track register writes and accepted poll requests at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask    = BOUNCE_MASK_RST;
            cur_up      = UP_PATTERN_RST;
            cur_down    = DOWN_PATTERN_RST;
            cur_press   = PRESS_PATTERN_RST;
            cur_release = RELEASE_PATTERN_RST;
            cur_count   = ACTIVE_COUNT_RST;
            for (int i = 0; i < BUTTON_COUNT; i++)
                btn_hist[i] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOUNCE_MASK:     cur_mask    = cfg_data;
                    REG_UP_PATTERN:      cur_up      = cfg_data;
                    REG_DOWN_PATTERN:    cur_down    = cfg_data;
                    REG_PRESS_PATTERN:   cur_press   = cfg_data;
                    REG_RELEASE_PATTERN: cur_release = cfg_data;
                    REG_ACTIVE_COUNT:    cur_count   = cfg_data[COUNT_WIDTH-1:0];
                    default:             ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                pending_scans.push_back(predict_scan(s_tdata[FIELD_WIDTH-1:0]));
                polls_accepted++;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[OUT_BITS-1:0]);
            if (pending_scans.size() == 0)
            begin
                $error("result received with no poll request outstanding: 0x%0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_scans.pop_front();
                check_field("down_flags", want.down_flags, got.down_flags);
                check_field("up_flags", want.up_flags, got.up_flags);
                check_field("press_flags", want.press_flags, got.press_flags);
                check_field("release_flags", want.release_flags, got.release_flags);
                check_field("any_down", 8'(want.any_down), 8'(got.any_down));
                check_field("padding", 8'h00, 8'(m_tdata[OUT_WIDTH-1:OUT_BITS]));
                results_checked++;
                press_seen   += $countones(want.press_flags);
                release_seen += $countones(want.release_flags);
            end
        end
    end

    // Result sink: stall pattern changes every so often; a hold request blocks it outright.
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one poll request and wait until it is accepted; bursts are separated by gaps.
    task automatic send_poll(input logic [FIELD_WIDTH-1:0] raw);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0 || !gaps_allowed) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 60);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering and wait until every expected result has been received.
    task automatic wait_results_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all six registers plus one spare index, back to back.
    task automatic apply_settings(input logic [7:0] mask, input logic [7:0] up,
                                  input logic [7:0] down, input logic [7:0] press,
                                  input logic [7:0] rel, input logic [3:0] count);
        write_reg(REG_BOUNCE_MASK, mask);
        write_reg(REG_UP_PATTERN, up);
        write_reg(REG_DOWN_PATTERN, down);
        write_reg(REG_PRESS_PATTERN, press);
        write_reg(REG_RELEASE_PATTERN, rel);
        // Upper data bits are random; only the low nibble counts.
        write_reg(REG_ACTIVE_COUNT, {4'($urandom), count});
        write_reg($urandom_range(0, 1) ? SPARE_INDEX_A : SPARE_INDEX_B, 8'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Raw samples from buttons that change level now and then and bounce after a change.
    function automatic logic [FIELD_WIDTH-1:0] next_raw();
        logic [FIELD_WIDTH-1:0] raw;
        for (int i = 0; i < FIELD_WIDTH; i++)
        begin
            if (bounce_left[i] == 0 && $urandom_range(0, 15) == 0)
            begin
                btn_level[i]   = !btn_level[i];
                bounce_left[i] = $urandom_range(0, 4);
            end
            if (bounce_left[i] > 0)
            begin
                raw[i] = $urandom_range(0, 1);
                bounce_left[i]--;
            end
            else
                raw[i] = btn_level[i];
        end
        return raw;
    endfunction

    // Mostly bouncing-button sequences, with some pure noise mixed in.
    task automatic send_mixed(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_poll(8'($urandom));
            else
                send_poll(next_raw());
        end
    endtask

    // Reset settings: full presses, holds, releases, and lanes out of step.
    task automatic test_reset_defaults();
        logic [7:0] seq [$];
        seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h0F, 8'h0F, 8'h0F, 8'hF0, 8'hF0, 8'hF0, 8'hAA, 8'h55,
                8'hAA, 8'h55, 8'h01, 8'h80, 8'h00};
        foreach (seq[k])
            send_poll(seq[k]);
        wait_results_drained();
    endtask

    // Zero, partial, full and oversized active counts; inactive lanes stay frozen.
    task automatic test_active_count();
        logic [3:0] counts [$];
        counts = '{4'd0, 4'd1, 4'd5, 4'd8, 4'd9, 4'd15, 4'd3, 4'd8};
        foreach (counts[k])
        begin
            apply_settings(8'hC7, 8'h00, 8'hFF, 8'h07, 8'hC0, counts[k]);
            send_mixed(12);
            wait_results_drained();
        end
    endtask

    // Press and release on the same tick, where the release sees the rewritten history.
    task automatic test_double_edge();
        apply_settings(8'h0F, 8'h5C, 8'hA3, 8'h0F, 8'h03, 4'd8);
        repeat (5) send_poll(8'hFF);
        send_mixed(6);
        wait_results_drained();
        // Empty mask: both edges fire on every tick and up equals down.
        apply_settings(8'h00, 8'h77, 8'h77, 8'h00, 8'h00, 4'd8);
        send_mixed(10);
        wait_results_drained();
    endtask

    // Extreme mask and pattern values.
    task automatic test_pattern_extremes();
        apply_settings(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 4'd15);
        send_mixed(14);
        wait_results_drained();
        apply_settings(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 4'd8);
        send_mixed(14);
        wait_results_drained();
        apply_settings(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 4'd8);
        send_mixed(14);
        wait_results_drained();
    endtask

    // Sink holds off for a long stretch while the source keeps offering requests.
    task automatic test_backpressure();
        apply_settings(8'hC7, 8'h00, 8'hFF, 8'h07, 8'hC0, 4'd8);
        gaps_allowed = 1'b0;
        hold_request = 1'b1;
        send_mixed(40);
        gaps_allowed = 1'b1;
        wait_results_drained();
    endtask

    // Random settings, biased so that press and release patterns can actually match.
    task automatic test_random_settings(input int phases, input int per_phase);
        logic [7:0] mask;
        logic [7:0] up;
        logic [7:0] down;
        logic [7:0] press;
        logic [7:0] rel;
        logic [3:0] count;
        for (int p = 0; p < phases; p++)
        begin
            mask  = 8'($urandom);
            count = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd8;
            if ($urandom_range(0, 3) != 0)
            begin
                // Recent samples down and older ones up marks a press; the reverse a release.
                press = mask & (8'hFF >> $urandom_range(1, 7));
                rel   = mask & ~(8'hFF >> $urandom_range(1, 7));
                down  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
                up    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            end
            else
            begin
                press = 8'($urandom);
                rel   = 8'($urandom);
                down  = 8'($urandom);
                up    = 8'($urandom);
            end
            apply_settings(mask, up, down, press, rel, count);
            send_mixed(per_phase);
            wait_results_drained();
        end
    endtask

    initial
    begin
        fail_count       = 0;
        polls_accepted   = 0;
        results_checked  = 0;
        press_seen       = 0;
        release_seen     = 0;
        settings_applied = 0;
        cycle_count      = 0;
        burst_left       = 0;
        gaps_allowed     = 1'b1;
        hold_request     = 1'b0;
        for (int i = 0; i < FIELD_WIDTH; i++)
        begin
            btn_level[i]   = 1'b0;
            bounce_left[i] = 0;
        end
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_active_count();
        test_double_edge();
        test_pattern_extremes();
        test_backpressure();
        test_random_settings(24, 72);

        if (pending_scans.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_scans.size());
            fail_count++;
        end
        $display("Checked %0d scan results from %0d poll requests under %0d register settings.",
                 results_checked, polls_accepted, settings_applied);
        $display("Press edges seen: %0d, release edges seen: %0d, mismatches: %0d.",
                 press_seen, release_seen, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
